FILE: hdl/mxt_pkg.sv
package mxt_pkg;

    localparam int VALUE_BITS = 32;
    localparam int CAPACITY   = 256;
    localparam int WORD_BITS  = 32;

    // root plus one node per level for every stored value
    localparam int POOL_NODES = CAPACITY * VALUE_BITS + 1;
    localparam int NODE_BITS  = $clog2(POOL_NODES);
    localparam int USED_BITS  = $clog2(POOL_NODES + 1);
    localparam int SUM_BITS   = USED_BITS + 1;
    localparam int LVL_BITS   = $clog2(VALUE_BITS + 1);

    typedef logic [WORD_BITS-1:0]  t_word;
    typedef logic [VALUE_BITS-1:0] t_val;
    typedef logic [NODE_BITS-1:0]  t_node;
    typedef logic [USED_BITS-1:0]  t_used;
    typedef logic [SUM_BITS-1:0]   t_sum;
    typedef logic [LVL_BITS-1:0]   t_lvl;
    typedef logic [1:0]            t_status;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    localparam t_status ST_INSERTED  = 2'd0;
    localparam t_status ST_ANSWERED  = 2'd1;
    localparam t_status ST_POOL_FULL = 2'd2;
    localparam t_status ST_EMPTY     = 2'd3;

    typedef struct packed {
        t_node one;
        t_node zero;
    } t_links;

    typedef struct packed {
        logic load;
        logic shift;
        logic ans_bit;
    } t_shift_ctl;

endpackage

FILE: hdl/mxt_in_if.sv
interface mxt_in_if;
    logic          valid;
    logic          ready;
    logic          mode;
    mxt_pkg::t_word value;

    modport source (output valid, output mode, output value, input ready);
    modport sink (input valid, input mode, input value, output ready);
endinterface

FILE: hdl/mxt_out_if.sv
interface mxt_out_if;
    logic             valid;
    logic             ready;
    mxt_pkg::t_status status;
    mxt_pkg::t_word   max_xor;

    modport source (output valid, output status, output max_xor, input ready);
    modport sink (input valid, input status, input max_xor, output ready);
endinterface

FILE: hdl/mxt_ram.sv
module mxt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/mxt_shift.sv
module mxt_shift (
    input  logic                i_clk,
    input  mxt_pkg::t_shift_ctl i_ctl,
    input  mxt_pkg::t_val       i_value,
    output logic                o_bit,
    output mxt_pkg::t_val       o_ans
);

    mxt_pkg::t_val r_val;
    mxt_pkg::t_val r_ans;

    // operand leaves msb first, answer bits enter at the lsb
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_val <= i_value;
            r_ans <= '0;
        end else if (i_ctl.shift) begin
            r_val <= r_val << 1;
            r_ans <= {r_ans[mxt_pkg::VALUE_BITS-2:0], i_ctl.ans_bit};
        end
    end

    assign o_bit = r_val[mxt_pkg::VALUE_BITS-1];
    assign o_ans = r_ans;

endmodule

FILE: hdl/max_xor_trie_query.sv
// maximum-xor binary trie
// i_in carries words {mode, value}: mode 0 inserts value into the set, mode 1
// asks for the greatest value XOR any stored entry. o_out returns one word
// {status, max_xor} per input word, in order. Only the low VALUE_BITS of
// value are used.
// the node memory holds two child links per node; each item walks one trie
// level per cycle through the memory's registered read port, one operand
// bit a cycle, except that an insert also passes through the allocation
// state for every node it has to create, after spotting the missing link.
// an empty query or a dropped insert is quicker than a full walk.
// one item is in flight at a time; a new word is taken as soon as the
// previous result sits in the output register.
// an insert that would overflow the node pool is dropped with status 2;
// a query before any insert gives status 3 and max_xor 0.
// reset empties the set at once (no memory sweep): the root reads as empty
// until first written and all other nodes are written when allocated.
// when the receiver stalls the result holds in the output register and the
// block stops before loading the next result.
module max_xor_trie_query (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mxt_in_if.sink    i_in,
    mxt_out_if.source o_out
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_ALLOC = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]       r_state, n_state;
    logic             r_mode, n_mode;
    mxt_pkg::t_lvl    r_lvl, n_lvl;
    mxt_pkg::t_node   r_node, n_node;
    mxt_pkg::t_used   r_used, n_used;
    mxt_pkg::t_links  r_links, n_links;
    logic             r_dead, n_dead;
    logic             r_present, n_present;
    logic             r_root_ok, n_root_ok;
    mxt_pkg::t_status r_status, n_status;
    logic             r_o_valid;
    mxt_pkg::t_status r_o_status;
    mxt_pkg::t_word   r_o_xor;

    mxt_pkg::t_shift_ctl sh_ctl;
    logic                bit_cur;
    mxt_pkg::t_val       ans;

    logic            ram_we;
    mxt_pkg::t_node  ram_addr;
    mxt_pkg::t_links ram_wdata;
    mxt_pkg::t_links ram_rdata;
    mxt_pkg::t_links rd_links;
    mxt_pkg::t_node  same_link;
    mxt_pkg::t_node  opp_link;
    logic            last_lvl;
    logic            fits;
    logic            in_acc;
    logic            out_load;

    mxt_ram #(
        .WIDTH ($bits(mxt_pkg::t_links)),
        .DEPTH (mxt_pkg::POOL_NODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    mxt_shift u_shift (
        .i_clk   (i_clk),
        .i_ctl   (sh_ctl),
        .i_value (mxt_pkg::t_val'(i_in.value)),
        .o_bit   (bit_cur),
        .o_ans   (ans)
    );

    assign in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // root is never swept after reset
    assign rd_links  = (r_node == '0 && !r_root_ok) ? '0 : ram_rdata;
    assign same_link = bit_cur ? rd_links.one : rd_links.zero;
    assign opp_link  = bit_cur ? rd_links.zero : rd_links.one;
    assign last_lvl  = (r_lvl == mxt_pkg::t_lvl'(1));
    // nodes missing on the path equal the levels still to go
    assign fits = (mxt_pkg::t_sum'(r_used) + mxt_pkg::t_sum'(r_lvl))
                  <= mxt_pkg::t_sum'(mxt_pkg::POOL_NODES);

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_lvl     = r_lvl;
        n_node    = r_node;
        n_used    = r_used;
        n_links   = r_links;
        n_dead    = r_dead;
        n_present = r_present;
        n_root_ok = r_root_ok;
        n_status  = r_status;
        sh_ctl    = '0;
        ram_we    = 1'b0;
        ram_addr  = '0;
        ram_wdata = r_links;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    sh_ctl.load = 1'b1;
                    n_mode      = i_in.mode;
                    n_lvl       = mxt_pkg::t_lvl'(mxt_pkg::VALUE_BITS);
                    n_node      = '0;
                    n_dead      = 1'b0;
                    if (i_in.mode == mxt_pkg::MODE_QUERY && !r_present) begin
                        n_status = mxt_pkg::ST_EMPTY;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (r_mode == mxt_pkg::MODE_INSERT) begin
                    if (same_link != '0) begin
                        n_node       = same_link;
                        ram_addr     = same_link;
                        sh_ctl.shift = 1'b1;
                        n_lvl        = r_lvl - mxt_pkg::t_lvl'(1);
                        if (last_lvl) begin
                            n_status  = mxt_pkg::ST_INSERTED;
                            n_present = 1'b1;
                            n_state   = S_OUT;
                        end
                    end else if (fits) begin
                        n_links = rd_links;
                        n_state = S_ALLOC;
                    end else begin
                        n_status = mxt_pkg::ST_POOL_FULL;
                        n_state  = S_OUT;
                    end
                end else begin
                    sh_ctl.shift = 1'b1;
                    n_lvl        = r_lvl - mxt_pkg::t_lvl'(1);
                    if (!r_dead && opp_link != '0) begin
                        sh_ctl.ans_bit = 1'b1;
                        n_node         = opp_link;
                    end else if (!r_dead && same_link != '0) begin
                        n_node = same_link;
                    end else begin
                        // broken path: remaining answer bits stay zero
                        n_dead = 1'b1;
                    end
                    ram_addr = n_node;
                    if (last_lvl) begin
                        n_status = mxt_pkg::ST_ANSWERED;
                        n_state  = S_OUT;
                    end
                end
            end
            S_ALLOC: begin
                ram_we    = 1'b1;
                ram_addr  = r_node;
                ram_wdata = r_links;
                if (bit_cur) begin
                    ram_wdata.one = mxt_pkg::t_node'(r_used);
                end else begin
                    ram_wdata.zero = mxt_pkg::t_node'(r_used);
                end
                if (r_node == '0) begin
                    n_root_ok = 1'b1;
                end
                n_node       = mxt_pkg::t_node'(r_used);
                n_used       = r_used + mxt_pkg::t_used'(1);
                n_links      = '0;
                sh_ctl.shift = 1'b1;
                n_lvl        = r_lvl - mxt_pkg::t_lvl'(1);
                if (last_lvl) begin
                    n_status  = mxt_pkg::ST_INSERTED;
                    n_present = 1'b1;
                    n_state   = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_o_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= mxt_pkg::t_used'(1);
            r_present <= 1'b0;
            r_root_ok <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_present <= n_present;
            r_root_ok <= n_root_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_lvl    <= n_lvl;
        r_node   <= n_node;
        r_links  <= n_links;
        r_dead   <= n_dead;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_status <= r_status;
            r_o_xor    <= mxt_pkg::t_word'(ans);
        end
    end

    assign o_out.valid   = r_o_valid;
    assign o_out.status  = r_o_status;
    assign o_out.max_xor = r_o_xor;

`ifndef ASSERT_OFF
    a_used_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mxt_pkg::t_sum'(r_used) <= mxt_pkg::t_sum'(mxt_pkg::POOL_NODES))
        else $error("node count beyond pool");

    a_alloc_below_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ALLOC |-> mxt_pkg::t_used'(r_node) < r_used)
        else $error("write to unallocated node");

    a_level_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK || r_state == S_ALLOC) |-> r_lvl != '0)
        else $error("walk past bottom level");

    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && in_acc) |=> (r_state == S_WALK || r_state == S_OUT))
        else $error("accepted word not started");
`endif

endmodule
